### design/avc_pkg.sv
// Shared types, constants and helpers for the alldifferent violation counter.
package avc_pkg;

    localparam int VALUE_W     = 32;
    localparam int VIOL_W      = 16;
    localparam int WSIZE_W     = 11;
    localparam int OP_W        = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_DEPTH = 1024;
    localparam int COUNT_WIDTH = 16;

    localparam logic [OP_W-1:0] OP_CLEAR  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_ADD    = OP_W'(1);
    localparam logic [OP_W-1:0] OP_CHANGE = OP_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_OFFSET = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = CFG_IDX_W'(1);

    localparam logic [VIOL_W-1:0] VIOL_MAX = '1;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] old_value;
        logic signed [VALUE_W-1:0] new_value;
    } t_in_item;

    typedef struct packed {
        logic [VIOL_W-1:0] violation;
        logic              new_in_window;
    } t_out_item;

    typedef enum logic [1:0] {
        RD_OLD_IN,
        RD_NEW_IN,
        RD_NEW_REG
    } t_rd_sel;

    typedef struct packed {
        logic    in_ready;
        logic    capture;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    dec_old;
        logic    inc_new;
        logic    sweep;
        logic    viol_clr;
        logic    load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] in_op;
        logic            old_hit;
        logic            new_hit;
        logic            values_equal;
        logic            sweep_last;
        logic            out_free;
    } t_dp_status;

    function automatic int addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

### design/avc_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface avc_in_if;
    logic               valid;
    logic               ready;
    avc_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface avc_out_if;
    logic               valid;
    logic               ready;
    avc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/alldifferent_violation_counter.sv
// Top level of the alldifferent violation counter.
// Usage: input transactions on i_in (operation, old_value, new_value) and one
// result transaction on o_out (violation, new_in_window) for each of them.
// Both channels are valid/ready; the result sits in an output register.
// Configuration: i_cfg_we/i_cfg_index/i_cfg_data write value_offset (index 0)
// and window_size (index 1); write only while the block is idle.
// Counts live in a COUNT_DEPTH x COUNT_WIDTH RAM with one write and one
// registered read port; each read-modify-write reads a count, then writes it.
// Per transaction: an add in the window reads and then increments the new
// value's count; a change of two unequal values decrements the old value's
// count if it is in the window, then increments the new value's count if it
// is; anything that touches no count goes straight to the result; a clear
// zeroes all COUNT_DEPTH counts. The result is loaded once that is done.
// Reset: a clearing pass writes zero to all COUNT_DEPTH entries;
// i_in.ready stays low until it is done.
// When the receiver stalls, the block finishes the transaction in hand and
// holds until the output register is free, then takes the next transaction.
module alldifferent_violation_counter #(
    parameter int COUNT_DEPTH = avc_pkg::COUNT_DEPTH,
    parameter int COUNT_WIDTH = avc_pkg::COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [avc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [avc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    avc_in_if.sink                            i_in,
    avc_out_if.source                         o_out
);

    avc_pkg::t_ctl_cmd   w_cmd;
    avc_pkg::t_dp_status w_status;

    avc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    avc_dp #(
        .COUNT_DEPTH (COUNT_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_status    (w_status)
    );

endmodule

### design/avc_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
module avc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [avc_pkg::addr_w(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                   i_wdata,
    input  logic                               i_re,
    input  logic [avc_pkg::addr_w(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                   o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/avc_ctrl.sv
// Controller state machine: sequences sweeps and count read-modify-writes.
module avc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  avc_pkg::t_dp_status   i_status,
    output avc_pkg::t_ctl_cmd     o_cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR   = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_MOD_OLD = 5'b00100,
        ST_MOD_NEW = 5'b01000,
        ST_FIN     = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_do_new, n_do_new;
    logic   r_clr_emit, n_clr_emit;
    logic   w_finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;   // clearing pass over the count memory
            r_do_new   <= 1'b0;
            r_clr_emit <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_do_new   <= n_do_new;
            r_clr_emit <= n_clr_emit;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_do_new   = r_do_new;
        n_clr_emit = r_clr_emit;
        w_finish   = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_sel = avc_pkg::RD_NEW_REG;

        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_last) begin
                    if (r_clr_emit) begin
                        n_clr_emit = 1'b0;
                        w_finish   = 1'b1;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_status.in_op)
                        avc_pkg::OP_CLEAR: begin
                            o_cmd.viol_clr = 1'b1;
                            n_clr_emit     = 1'b1;
                            n_state        = ST_CLEAR;
                        end
                        avc_pkg::OP_ADD: begin
                            if (i_status.new_hit) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = avc_pkg::RD_NEW_IN;
                                n_state      = ST_MOD_NEW;
                            end else begin
                                w_finish = 1'b1;
                            end
                        end
                        avc_pkg::OP_CHANGE: begin
                            // distinct values never share a slot
                            if (!i_status.values_equal && i_status.old_hit) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = avc_pkg::RD_OLD_IN;
                                n_do_new     = i_status.new_hit;
                                n_state      = ST_MOD_OLD;
                            end else if (!i_status.values_equal && i_status.new_hit) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = avc_pkg::RD_NEW_IN;
                                n_state      = ST_MOD_NEW;
                            end else begin
                                w_finish = 1'b1;
                            end
                        end
                        default: begin
                            w_finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_MOD_OLD: begin
                o_cmd.dec_old = 1'b1;
                if (r_do_new) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = avc_pkg::RD_NEW_REG;
                    n_state      = ST_MOD_NEW;
                end else begin
                    w_finish = 1'b1;
                end
            end
            ST_MOD_NEW: begin
                o_cmd.inc_new = 1'b1;
                w_finish      = 1'b1;
            end
            ST_FIN: begin
                w_finish = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // result goes out now if the output register is free, else wait in FIN
        if (w_finish) begin
            if (i_status.out_free) begin
                o_cmd.load_out = 1'b1;
                n_state        = ST_IDLE;
            end else begin
                n_state = ST_FIN;
            end
        end
    end

endmodule

### design/avc_dp.sv
// Datapath: config registers, window check, count memory, violation and output register.
module avc_dp #(
    parameter int COUNT_DEPTH = avc_pkg::COUNT_DEPTH,
    parameter int COUNT_WIDTH = avc_pkg::COUNT_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [avc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [avc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    avc_in_if.sink                            i_in,
    avc_out_if.source                         o_out,
    input  avc_pkg::t_ctl_cmd                 i_cmd,
    output avc_pkg::t_dp_status               o_status
);

    localparam int AW = avc_pkg::addr_w(COUNT_DEPTH);
    localparam int VW = avc_pkg::VALUE_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic signed [VW-1:0]            r_off;
    logic [avc_pkg::WSIZE_W-1:0]     r_wsize;
    logic [VW-1:0]                   w_limit;
    logic [VW-1:0]                   w_old_delta, w_new_delta;
    logic                            w_old_hit, w_new_hit;
    logic                            w_inwin_in;
    logic [AW-1:0]                   r_old_slot, r_new_slot;
    logic                            r_inwin, n_inwin;
    logic [AW-1:0]                   r_sweep_addr;
    logic                            w_sweep_last;
    logic [avc_pkg::VIOL_W-1:0]      r_viol, n_viol;
    logic                            r_out_valid;
    avc_pkg::t_out_item              r_out;
    logic                            w_out_free;

    logic                            w_we, w_re;
    logic [AW-1:0]                   w_waddr, w_raddr;
    logic [COUNT_WIDTH-1:0]          w_wdata, w_rdata;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_wsize <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                avc_pkg::CFG_VALUE_OFFSET: r_off   <= i_cfg_data;
                avc_pkg::CFG_WINDOW_SIZE:  r_wsize <= i_cfg_data[avc_pkg::WSIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // window check on the incoming values
    assign w_limit = (VW'(r_wsize) > VW'(COUNT_DEPTH)) ? VW'(COUNT_DEPTH) : VW'(r_wsize);
    assign w_old_delta = i_in.data.old_value - r_off;
    assign w_new_delta = i_in.data.new_value - r_off;
    assign w_old_hit = (i_in.data.old_value >= r_off) && (w_old_delta < w_limit);
    assign w_new_hit = (i_in.data.new_value >= r_off) && (w_new_delta < w_limit);
    assign w_inwin_in = w_new_hit && ((i_in.data.operation == avc_pkg::OP_ADD) ||
                                      (i_in.data.operation == avc_pkg::OP_CHANGE));

    assign n_inwin = i_cmd.capture ? w_inwin_in : r_inwin;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_old_slot <= w_old_delta[AW-1:0];
            r_new_slot <= w_new_delta[AW-1:0];
            r_inwin    <= w_inwin_in;
        end
    end

    // sweep address for clearing
    assign w_sweep_last = (r_sweep_addr == AW'(COUNT_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep_addr <= w_sweep_last ? '0 : r_sweep_addr + AW'(1);
        end
    end

    // count memory access
    always_comb begin
        case (i_cmd.rd_sel)
            avc_pkg::RD_OLD_IN: w_raddr = w_old_delta[AW-1:0];
            avc_pkg::RD_NEW_IN: w_raddr = w_new_delta[AW-1:0];
            default:            w_raddr = r_new_slot;
        endcase
    end
    assign w_re = i_cmd.rd_en;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_new_slot;
        w_wdata = w_rdata + CNT_ONE;
        if (i_cmd.sweep) begin
            w_we    = 1'b1;
            w_waddr = r_sweep_addr;
            w_wdata = '0;
        end else if (i_cmd.dec_old) begin
            w_we    = (w_rdata != '0);
            w_waddr = r_old_slot;
            w_wdata = w_rdata - CNT_ONE;
        end else if (i_cmd.inc_new) begin
            w_we    = (w_rdata != CNT_MAX);
        end
    end

    avc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (COUNT_DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // running violation, saturating both ways
    always_comb begin
        n_viol = r_viol;
        if (i_cmd.viol_clr) begin
            n_viol = '0;
        end else if (i_cmd.dec_old) begin
            if ((w_rdata > CNT_ONE) && (r_viol != '0)) begin
                n_viol = r_viol - avc_pkg::VIOL_W'(1);
            end
        end else if (i_cmd.inc_new) begin
            if ((w_rdata != CNT_MAX) && (w_rdata != '0) && (r_viol != avc_pkg::VIOL_MAX)) begin
                n_viol = r_viol + avc_pkg::VIOL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viol <= '0;
        end else begin
            r_viol <= n_viol;
        end
    end

    // output register
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.violation     <= n_viol;
            r_out.new_in_window <= n_inwin;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign i_in.ready  = i_cmd.in_ready;

    assign o_status.in_valid     = i_in.valid;
    assign o_status.in_op        = i_in.data.operation;
    assign o_status.old_hit      = w_old_hit;
    assign o_status.new_hit      = w_new_hit;
    assign o_status.values_equal = (i_in.data.old_value == i_in.data.new_value);
    assign o_status.sweep_last   = w_sweep_last;
    assign o_status.out_free     = w_out_free;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the alldifferent violation counter: directed table, a count ramp, then random.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import avc_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int RANDOM_ITEMS = 880;
    localparam int PLAN_ROWS    = 28;
    localparam int MAX_PRINTED  = 40;
    localparam int RAMP_LEN     = 20;

    localparam logic [OP_W-1:0]        OP_UNKNOWN = OP_W'(3);
    localparam logic [COUNT_WIDTH-1:0] COUNT_TOP  = '1;

    typedef struct packed {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [OP_W-1:0]      op;
        logic [VALUE_W-1:0]   oldv;
        logic [VALUE_W-1:0]   newv;   // register data on register rows
        bit                   known;
        logic [VIOL_W-1:0]    viol;
        logic                 inwin;
    } t_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    avc_in_if  in_ch ();
    avc_out_if out_ch ();

    alldifferent_violation_counter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Histogram model of the block
    logic signed [VALUE_W-1:0] win_base;
    logic [WSIZE_W-1:0]        win_len;
    logic [COUNT_WIDTH-1:0]    tally [COUNT_DEPTH];
    logic [VIOL_W-1:0]         excess;

    t_out_item   reports_due [$];
    t_out_item   head;
    int          mismatches = 0;
    int          cycles     = 0;
    bit          idle_on    = 1'b0;
    int unsigned hold_left  = 0;

    // is_reg, idx, op, old, new (or register data), known, violation, in window
    t_row plan [PLAN_ROWS] = '{
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'h0,         1'b1, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_UNKNOWN, 32'h1,         32'h2,         1'b1, 16'd0, 1'b0},
        '{1'b1, CFG_VALUE_OFFSET, OP_CLEAR,   32'h0,         32'hFFFF_FFFC, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_WINDOW_SIZE,  OP_CLEAR,   32'h0,         32'd8,         1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'hFFFF_FFFC, 1'b1, 16'd0, 1'b1},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'hFFFF_FFFC, 1'b1, 16'd1, 1'b1},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'd3,         1'b1, 16'd1, 1'b1},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'd4,         1'b1, 16'd1, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'hFFFF_FFFB, 1'b1, 16'd1, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_CHANGE,  32'hFFFF_FFFC, 32'hFFFF_FFFC, 1'b1, 16'd1, 1'b1},
        '{1'b0, CFG_VALUE_OFFSET, OP_CHANGE,  32'hFFFF_FFFC, 32'd3,         1'b1, 16'd1, 1'b1},
        '{1'b0, CFG_VALUE_OFFSET, OP_CHANGE,  32'd100,       32'd0,         1'b1, 16'd1, 1'b1},
        '{1'b0, CFG_VALUE_OFFSET, OP_CHANGE,  32'd2,         32'd50,        1'b1, 16'd1, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_CHANGE,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'd0, 1'b0},
        '{1'b1, CFG_VALUE_OFFSET, OP_CLEAR,   32'h0,         32'h7FFF_FF00, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_WINDOW_SIZE,  OP_CLEAR,   32'h0,         32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'h7FFF_FFFF, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_CHANGE,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_VALUE_OFFSET, OP_CLEAR,   32'h0,         32'h8000_0000, 1'b0, 16'd0, 1'b0},
        '{1'b1, CFG_WINDOW_SIZE,  OP_CLEAR,   32'h0,         32'd1024,      1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'h8000_0000, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'h8000_03FF, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_ADD,     32'h0,         32'h8000_0400, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_CHANGE,  32'h8000_03FF, 32'h8000_0000, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_UNKNOWN, 32'h0,         32'h8000_0000, 1'b0, 16'd0, 1'b0},
        '{1'b0, CFG_VALUE_OFFSET, OP_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0, 1'b0}
    };

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
    end

    function automatic bit slot_of(input logic signed [VALUE_W-1:0] v,
                                   output int unsigned slot);
        int unsigned        lim;
        logic [VALUE_W-1:0] delta;
        lim  = (win_len > COUNT_DEPTH) ? COUNT_DEPTH : int'(win_len);
        slot = 0;
        if (v < win_base) return 1'b0;
        delta = v - win_base;
        if (delta >= lim) return 1'b0;
        slot = delta;
        return 1'b1;
    endfunction

    function automatic void tally_add(input logic signed [VALUE_W-1:0] v);
        int unsigned s;
        if (!slot_of(v, s)) return;
        if (tally[s] == COUNT_TOP) return;
        tally[s] = tally[s] + 1'b1;
        if (tally[s] >= 2 && excess != VIOL_MAX) excess = excess + 1'b1;
    endfunction

    function automatic void tally_remove(input logic signed [VALUE_W-1:0] v);
        int unsigned s;
        if (!slot_of(v, s)) return;
        if (tally[s] == '0) return;
        tally[s] = tally[s] - 1'b1;
        if (tally[s] >= 1 && excess != '0) excess = excess - 1'b1;
    endfunction

    function automatic t_out_item step_histogram(input t_in_item it);
        t_out_item   r;
        int unsigned s;
        r.new_in_window = 1'b0;
        case (it.operation)
            OP_CLEAR: begin
                tally  = '{default: '0};
                excess = '0;
            end
            OP_ADD: begin
                r.new_in_window = slot_of(it.new_value, s);
                tally_add(it.new_value);
            end
            OP_CHANGE: begin
                r.new_in_window = slot_of(it.new_value, s);
                if (it.old_value != it.new_value) begin
                    tally_remove(it.old_value);
                    tally_add(it.new_value);
                end
            end
            default: ;
        endcase
        r.violation = excess;
        return r;
    endfunction

    function automatic t_in_item item_of(input logic [OP_W-1:0] op,
                                         input logic [VALUE_W-1:0] oldv,
                                         input logic [VALUE_W-1:0] newv);
        t_in_item it;
        it.operation = op;
        it.old_value = oldv;
        it.new_value = newv;
        return it;
    endfunction

    // mostly short, now and then long
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    // Values cluster around the window so counts collide often
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned span;
        span = (win_len > COUNT_DEPTH) ? COUNT_DEPTH : int'(win_len);
        case ($urandom_range(0, 19))
            0, 1, 2: return $urandom();
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return win_base + span;
            default: return win_base + $urandom_range(0, span + 3) - 2;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic send_item(input t_in_item it, input bit known, input t_out_item typed);
        int        gap;
        t_out_item due;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        due = step_histogram(it);
        reports_due.push_back(known ? typed : due);
    endtask

    // Drop valid and wait until every pending result has come out
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_VALUE_OFFSET) win_base = data;
        else win_len = data[WSIZE_W-1:0];
    endtask

    always @(negedge i_clk) begin
        if (idle_on && hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            out_ch.ready <= 1'b0;
            hold_left = gap_len() - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (reports_due.size() == 0) begin
                report_mismatch("result with no transaction pending", 32'(out_ch.data), '0);
            end else begin
                head = reports_due.pop_front();
                if (out_ch.data.violation !== head.violation)
                    report_mismatch("violation", 32'(out_ch.data.violation), 32'(head.violation));
                if (out_ch.data.new_in_window !== head.new_in_window)
                    report_mismatch("new_in_window", 32'(out_ch.data.new_in_window),
                                    32'(head.new_in_window));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_in_item           it;
        logic [VALUE_W-1:0] ov;
        logic [VALUE_W-1:0] nv;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] upper;
        logic [WSIZE_W-1:0] wsz;
        logic [VALUE_W-1:0] placed [$];
        int                 roll;
        int                 k;
        int                 n;
        int                 sent;

        win_base = '0;
        win_len  = '0;
        tally    = '{default: '0};
        excess   = '0;
        idle_on  = 1'b1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].is_reg) begin
                drain();
                write_reg(plan[r].idx, plan[r].newv);
            end else begin
                send_item(item_of(plan[r].op, plan[r].oldv, plan[r].newv), plan[r].known,
                          {plan[r].viol, plan[r].inwin});
            end
        end

        // Drive one count up, then back down past zero; back to back with no stalls.
        drain();
        idle_on = 1'b0;
        write_reg(CFG_VALUE_OFFSET, '0);
        write_reg(CFG_WINDOW_SIZE, 32'd4);
        send_item(item_of(OP_CLEAR, '0, '0), 1'b0, '0);
        repeat (RAMP_LEN) send_item(item_of(OP_ADD, '0, 32'd0), 1'b0, '0);
        repeat (3) send_item(item_of(OP_ADD, '0, 32'd1), 1'b0, '0);
        repeat (2) send_item(item_of(OP_CHANGE, 32'd1, 32'd9), 1'b0, '0);
        repeat (RAMP_LEN + 1) send_item(item_of(OP_CHANGE, 32'd0, 32'd9), 1'b0, '0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       base = $urandom();
                1:       base = $urandom_range(0, 100) - 50;
                2:       base = 32'h8000_0000 + $urandom_range(0, 40);
                default: base = 32'h7FFF_FFFF - $urandom_range(0, 40);
            endcase
            case ($urandom_range(0, 11))
                0:       wsz = '0;
                1:       wsz = WSIZE_W'(COUNT_DEPTH);
                2:       wsz = '1;
                3:       wsz = WSIZE_W'($urandom_range(0, 2047));
                default: wsz = WSIZE_W'($urandom_range(1, 24));
            endcase
            upper = $urandom();
            // sometimes the offset stays, so old counts are reused under a new size
            if ($urandom_range(0, 4) != 0) write_reg(CFG_VALUE_OFFSET, base);
            write_reg(CFG_WINDOW_SIZE, {upper[VALUE_W-1:WSIZE_W], wsz});
            placed.delete();
            n = $urandom_range(60, 160);
            for (int j = 0; j < n && sent < RANDOM_ITEMS; j++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    it = item_of(OP_CLEAR, $urandom(), $urandom());
                    placed.delete();
                end else if (roll < 6) begin
                    it = item_of(OP_UNKNOWN, $urandom(), $urandom());
                end else if (roll < 48) begin
                    nv = pick_value();
                    it = item_of(OP_ADD, $urandom(), nv);
                    placed.push_back(nv);
                end else begin
                    // mostly move a variable that was really placed
                    k = -1;
                    if (placed.size() != 0 && $urandom_range(0, 3) != 0) begin
                        k  = $urandom_range(0, placed.size() - 1);
                        ov = placed[k];
                    end else begin
                        ov = pick_value();
                    end
                    nv = ($urandom_range(0, 7) == 0) ? ov : pick_value();
                    if (k >= 0) placed[k] = nv;
                    it = item_of(OP_CHANGE, ov, nv);
                end
                send_item(it, 1'b0, '0);
                sent++;
            end
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
design/avc_pkg.sv
design/avc_if.sv
design/avc_ram.sv
design/avc_ctrl.sv
design/avc_dp.sv
design/alldifferent_violation_counter.sv
tb/sv/testbench.sv
